// ----- src/hsl_to_rgb_converter_top_macros.svh -----
// Assertion macros shared by the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HSLC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hslc assertion failed");

// Implication with a fixed delay in cycles.
`define HSLC_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("hslc latency assertion failed");

`endif

// ----- src/hslc_pkg.sv -----
// Package for the HSL to RGB converter: payload types, constants, byte scaling.
`timescale 1ns / 1ps
`default_nettype none

package hslc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int BYTE_W = 8;

  localparam int HUE_WRAP = 360;
  localparam int PCT_MAX  = 100;

  // Pipeline depth of each unit
  localparam int NORM_LAT = 2;
  localparam int TMP_LAT  = 3;
  localparam int RAMP_LAT = 4;

  // Reciprocal of 100 for the byte scaling, exact for numerators below 43690
  localparam int BYTE_RECIP = 20972;
  localparam int BYTE_SHIFT = 21;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] lightness;
  } hslc_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } hslc_out_t;

  // Segment of the piecewise channel ramp
  typedef enum logic [1:0] {
    RAMP_RISE,
    RAMP_HIGH,
    RAMP_FALL,
    RAMP_LOW
  } ramp_seg_t;

  // Percent 0..100 to byte 0..255, rounding half up
  function automatic logic [BYTE_W-1:0] pct_to_byte(input logic [PCT_W-1:0] pct);
    logic [14:0] num;
    logic [29:0] prod;
    num  = 15'(pct) * 15'd255 + 15'd50;
    prod = 30'(num) * 30'(BYTE_RECIP);
    return prod[BYTE_SHIFT +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

// ----- src/hslc_norm.sv -----
// Fixed-point normalizer: q = floor(x * 2^FRAC_BITS / DIVISOR) in two stages.
`timescale 1ns / 1ps
`default_nettype none

module hslc_norm #(
  parameter int FRAC_BITS = hslc_pkg::FRAC_BITS_DEF,
  parameter int IN_W      = hslc_pkg::PCT_W,
  parameter int DIVISOR   = hslc_pkg::PCT_MAX
) (
  input  logic                 clk,
  input  logic [IN_W-1:0]      x,
  output logic [FRAC_BITS:0]   q
);

  localparam int Q_W     = FRAC_BITS + 1;
  localparam int GUARD   = IN_W + 1;
  localparam int RECIP_W = FRAC_BITS + GUARD + 1;
  localparam int PROD_W  = IN_W + RECIP_W;
  localparam int NUM_W   = IN_W + FRAC_BITS + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((RECIP_W'(1) << (FRAC_BITS + GUARD)) / DIVISOR);

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    est_nxt;
  logic [Q_W-1:0]    est_r;
  logic [IN_W-1:0]   x_r;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  back;
  logic [NUM_W-1:0]  rem;
  logic [Q_W-1:0]    q_nxt;
  logic [Q_W-1:0]    q_r;

  // Stage 1: reciprocal estimate, at most one below the true quotient
  always_comb begin
    prod    = PROD_W'(x) * PROD_W'(RECIP);
    est_nxt = prod[GUARD +: Q_W];
  end

  always_ff @(posedge clk) begin
    x_r   <= x;
    est_r <= est_nxt;
  end

  // Stage 2: remainder check and correction
  always_comb begin
    num   = NUM_W'(x_r) << FRAC_BITS;
    back  = NUM_W'(est_r) * NUM_W'(DIVISOR);
    rem   = num - back;
    q_nxt = (rem >= NUM_W'(DIVISOR)) ? est_r + Q_W'(1) : est_r;
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- src/hslc_tmp.sv -----
// temp1/temp2 computation and per-channel hue offsets, three stages.
`timescale 1ns / 1ps
`default_nettype none

module hslc_tmp #(
  parameter int FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic [FRAC_BITS:0] l,
  input  logic [FRAC_BITS:0] s,
  input  logic [FRAC_BITS:0] h,
  output logic [FRAC_BITS:0] t1,
  output logic [FRAC_BITS:0] t2,
  output logic [FRAC_BITS:0] d,
  output logic [FRAC_BITS:0] tr,
  output logic [FRAC_BITS:0] tg,
  output logic [FRAC_BITS:0] tb
);

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE   = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] THIRD = ONE / 3;

  logic [2*W-1:0] ls_prod;
  logic [W-1:0]   ls_nxt;
  logic [W:0]     tr_sum;
  logic [W-1:0]   tr_nxt;
  logic [W-1:0]   tb_nxt;
  logic [W-1:0]   ls_r, l_a_r, s_a_r;
  logic [W-1:0]   tr_a_r, tg_a_r, tb_a_r;

  logic           lt_half;
  logic [W:0]     t1_wide;
  logic [W-1:0]   t1_nxt;
  logic [W-1:0]   t1_b_r, l_b_r;
  logic [W-1:0]   tr_b_r, tg_b_r, tb_b_r;

  logic [W:0]     two_l;
  logic [W:0]     t2_wide;
  logic [W-1:0]   t2_nxt;
  logic [W-1:0]   d_nxt;
  logic [W-1:0]   t1_c_r, t2_c_r, d_c_r;
  logic [W-1:0]   tr_c_r, tg_c_r, tb_c_r;

  // Stage A: l*s product and offsets with wrap
  always_comb begin
    ls_prod = (2*W)'(l) * (2*W)'(s);
    ls_nxt  = ls_prod[FRAC_BITS +: W];
    tr_sum  = (W+1)'(h) + (W+1)'(THIRD);
    tr_nxt  = (tr_sum > (W+1)'(ONE)) ? W'(tr_sum - (W+1)'(ONE)) : W'(tr_sum);
    tb_nxt  = (h >= THIRD) ? h - THIRD : h + (ONE - THIRD);
  end

  always_ff @(posedge clk) begin
    ls_r   <= ls_nxt;
    l_a_r  <= l;
    s_a_r  <= s;
    tr_a_r <= tr_nxt;
    tg_a_r <= h;
    tb_a_r <= tb_nxt;
  end

  // Stage B: temp1, capped at one
  always_comb begin
    lt_half = ((W+1)'(l_a_r) << 1) < (W+1)'(ONE);
    if (lt_half) begin
      t1_wide = (W+1)'(l_a_r) + (W+1)'(ls_r);
    end else begin
      t1_wide = (W+1)'(l_a_r) + (W+1)'(s_a_r) - (W+1)'(ls_r);
    end
    t1_nxt = (t1_wide > (W+1)'(ONE)) ? ONE : t1_wide[W-1:0];
  end

  always_ff @(posedge clk) begin
    t1_b_r <= t1_nxt;
    l_b_r  <= l_a_r;
    tr_b_r <= tr_a_r;
    tg_b_r <= tg_a_r;
    tb_b_r <= tb_a_r;
  end

  // Stage C: temp2 floored at zero, then the ramp height
  always_comb begin
    two_l   = (W+1)'(l_b_r) << 1;
    t2_wide = (two_l >= (W+1)'(t1_b_r)) ? two_l - (W+1)'(t1_b_r) : '0;
    t2_nxt  = t2_wide[W-1:0];
    d_nxt   = (t1_b_r >= t2_nxt) ? t1_b_r - t2_nxt : '0;
  end

  always_ff @(posedge clk) begin
    t1_c_r <= t1_b_r;
    t2_c_r <= t2_nxt;
    d_c_r  <= d_nxt;
    tr_c_r <= tr_b_r;
    tg_c_r <= tg_b_r;
    tb_c_r <= tb_b_r;
  end

  assign t1 = t1_c_r;
  assign t2 = t2_c_r;
  assign d  = d_c_r;
  assign tr = tr_c_r;
  assign tg = tg_c_r;
  assign tb = tb_c_r;

endmodule

`default_nettype wire

// ----- src/hslc_ramp.sv -----
// One channel: piecewise ramp on the hue offset, then scaling to whole percent.
`timescale 1ns / 1ps
`default_nettype none

module hslc_ramp #(
  parameter int FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [FRAC_BITS:0]          t,
  input  logic [FRAC_BITS:0]          t1,
  input  logic [FRAC_BITS:0]          t2,
  input  logic [FRAC_BITS:0]          d,
  output logic [hslc_pkg::PCT_W-1:0]  pct
);

  import hslc_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam longint unsigned ONE_I = 64'd1 << FRAC_BITS;
  localparam logic [W-1:0] ONE       = W'(ONE_I);
  localparam logic [W-1:0] TWO_THIRD = W'((2 * ONE_I) / 3);

  ramp_seg_t      seg_nxt;
  logic [W+2:0]   t6;
  logic           six_lt, two_lt, three_lt;
  logic [W-1:0]   k;
  logic [W+2:0]   k6;
  logic [W-1:0]   f_nxt;
  ramp_seg_t      seg1_r;
  logic [W-1:0]   f_r, t1_1_r, t2_1_r, d_r;

  logic [2*W-1:0] df_prod;
  ramp_seg_t      seg2_r;
  logic [W-1:0]   df_r, t1_2_r, t2_2_r;

  logic [W:0]     v_nxt;
  logic [W:0]     v_r;

  logic [W+7:0]   v100;
  logic [8:0]     p_wide;
  logic [PCT_W-1:0] pct_nxt;
  logic [PCT_W-1:0] pct_r;

  // Stage 1: segment select and slope factor
  always_comb begin
    t6       = (W+3)'(t) * (W+3)'(6);
    six_lt   = t6 < (W+3)'(ONE);
    two_lt   = ((W+1)'(t) << 1) < (W+1)'(ONE);
    three_lt = ((W+2)'(t) * (W+2)'(3)) < (W+2)'(2 * ONE_I);
    k        = (TWO_THIRD >= t) ? TWO_THIRD - t : '0;
    k6       = (W+3)'(k) * (W+3)'(6);
    if (six_lt) begin
      seg_nxt = RAMP_RISE;
    end else if (two_lt) begin
      seg_nxt = RAMP_HIGH;
    end else if (three_lt) begin
      seg_nxt = RAMP_FALL;
    end else begin
      seg_nxt = RAMP_LOW;
    end
    f_nxt = (seg_nxt == RAMP_RISE) ? t6[W-1:0] : k6[W-1:0];
  end

  always_ff @(posedge clk) begin
    seg1_r <= seg_nxt;
    f_r    <= f_nxt;
    t1_1_r <= t1;
    t2_1_r <= t2;
    d_r    <= d;
  end

  // Stage 2: slope times height
  assign df_prod = (2*W)'(d_r) * (2*W)'(f_r);

  always_ff @(posedge clk) begin
    seg2_r <= seg1_r;
    df_r   <= df_prod[FRAC_BITS +: W];
    t1_2_r <= t1_1_r;
    t2_2_r <= t2_1_r;
  end

  // Stage 3: channel value per segment
  always_comb begin
    case (seg2_r)
      RAMP_RISE: v_nxt = (W+1)'(t2_2_r) + (W+1)'(df_r);
      RAMP_HIGH: v_nxt = (W+1)'(t1_2_r);
      RAMP_FALL: v_nxt = (W+1)'(t2_2_r) + (W+1)'(df_r);
      RAMP_LOW:  v_nxt = (W+1)'(t2_2_r);
      default:   v_nxt = (W+1)'(t2_2_r);
    endcase
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  // Stage 4: whole percent, capped
  always_comb begin
    v100    = (W+8)'(v_r) * (W+8)'(PCT_MAX);
    p_wide  = v100[FRAC_BITS +: 9];
    pct_nxt = (p_wide > 9'(PCT_MAX)) ? PCT_W'(PCT_MAX) : p_wide[PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    pct_r <= pct_nxt;
  end

  assign pct = pct_r;

endmodule

`default_nettype wire

// ----- src/hsl_to_rgb_converter_top.sv -----
// Top level of the HSL to RGB converter: input clamp, unit pipeline, output stage.
`timescale 1ns / 1ps
`default_nettype none

// HSL to RGB converter. A transaction is accepted on each clock edge with
// start high and busy low; busy is high only while rst_n is asserted, so the
// block takes one color every cycle. The result appears on out_item for one
// cycle with out_valid high, after normalization (reciprocal multiply and
// correction), temp1/temp2 and hue offsets, the per-channel ramp and percent
// scaling, and the byte output register. There is no back-pressure: results
// must be taken when out_valid is high. Hue 360..511 wraps by 360; saturation
// and lightness above 100 saturate to 100.

`include "hsl_to_rgb_converter_top_macros.svh"

module hsl_to_rgb_converter_top #(
  parameter int FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hslc_pkg::hslc_in_t  in_item,
  output logic                out_valid,
  output hslc_pkg::hslc_out_t out_item
);

  import hslc_pkg::*;

  localparam int W        = FRAC_BITS + 1;
  localparam int SIDE_LAT = NORM_LAT + TMP_LAT + RAMP_LAT;
  localparam int PIPE_LAT = SIDE_LAT + 1;

  logic                 in_fire;
  logic [HUE_W-1:0]     hue_c;
  logic [PCT_W-1:0]     sat_c;
  logic [PCT_W-1:0]     lit_c;
  logic                 zs_c;

  logic [W-1:0]         l_n, s_n, h_n;
  logic [W-1:0]         t1, t2, d, tr, tg, tb;
  logic [PCT_W-1:0]     pct_r_ch, pct_g_ch, pct_b_ch;

  logic [PIPE_LAT-1:0]           valid_r;
  logic [PIPE_LAT-1:0]           valid_nxt;
  logic [SIDE_LAT-1:0]           zs_pipe_r;
  logic [SIDE_LAT-1:0][PCT_W-1:0] lit_pipe_r;

  logic                 zs_end;
  logic [PCT_W-1:0]     lit_end;
  hslc_out_t            out_nxt;
  hslc_out_t            out_item_r;
  logic                 out_zs_r;
  logic [PCT_W-1:0]     out_lit_r;

  assign busy    = ~rst_n;
  assign in_fire = start & ~busy;

  // Input range handling
  always_comb begin
    hue_c = (in_item.hue >= HUE_W'(HUE_WRAP)) ? in_item.hue - HUE_W'(HUE_WRAP)
                                              : in_item.hue;
    sat_c = (in_item.saturation > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                   : in_item.saturation;
    lit_c = (in_item.lightness > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                  : in_item.lightness;
    zs_c  = (sat_c == '0);
  end

  // Normalize to fixed point
  hslc_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(PCT_W), .DIVISOR(PCT_MAX)) u_norm_l (
    .clk (clk),
    .x   (lit_c),
    .q   (l_n)
  );

  hslc_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(PCT_W), .DIVISOR(PCT_MAX)) u_norm_s (
    .clk (clk),
    .x   (sat_c),
    .q   (s_n)
  );

  hslc_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(HUE_W), .DIVISOR(HUE_WRAP)) u_norm_h (
    .clk (clk),
    .x   (hue_c),
    .q   (h_n)
  );

  // temp1, temp2 and channel offsets
  hslc_tmp #(.FRAC_BITS(FRAC_BITS)) u_tmp (
    .clk (clk),
    .l   (l_n),
    .s   (s_n),
    .h   (h_n),
    .t1  (t1),
    .t2  (t2),
    .d   (d),
    .tr  (tr),
    .tg  (tg),
    .tb  (tb)
  );

  // One ramp per channel
  hslc_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_r (
    .clk (clk),
    .t   (tr),
    .t1  (t1),
    .t2  (t2),
    .d   (d),
    .pct (pct_r_ch)
  );

  hslc_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_g (
    .clk (clk),
    .t   (tg),
    .t1  (t1),
    .t2  (t2),
    .d   (d),
    .pct (pct_g_ch)
  );

  hslc_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_b (
    .clk (clk),
    .t   (tb),
    .t1  (t1),
    .t2  (t2),
    .d   (d),
    .pct (pct_b_ch)
  );

  // Valid bits along the pipeline
  assign valid_nxt = {valid_r[PIPE_LAT-2:0], in_fire};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Zero-saturation flag and lightness ride alongside the units
  always_ff @(posedge clk) begin
    zs_pipe_r  <= {zs_pipe_r[SIDE_LAT-2:0], zs_c};
    lit_pipe_r <= {lit_pipe_r[SIDE_LAT-2:0], lit_c};
  end

  assign zs_end  = zs_pipe_r[SIDE_LAT-1];
  assign lit_end = lit_pipe_r[SIDE_LAT-1];

  // Output stage: percent to byte
  always_comb begin
    if (zs_end) begin
      out_nxt.red   = pct_to_byte(lit_end);
      out_nxt.green = pct_to_byte(lit_end);
      out_nxt.blue  = pct_to_byte(lit_end);
    end else begin
      out_nxt.red   = pct_to_byte(pct_r_ch);
      out_nxt.green = pct_to_byte(pct_g_ch);
      out_nxt.blue  = pct_to_byte(pct_b_ch);
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
    out_zs_r   <= zs_end;
    out_lit_r  <= lit_end;
  end

  assign out_valid = valid_r[PIPE_LAT-1];
  assign out_item  = out_item_r;

  // Checks
  `HSLC_ASSERT_DELAY(a_latency, in_fire, PIPE_LAT, out_valid)
  `HSLC_ASSERT_IMPL(a_no_orphan, out_valid, $past(in_fire, PIPE_LAT))
  `HSLC_ASSERT_IMPL(a_gray, out_valid && out_zs_r, (out_item.red == out_item.green) && (out_item.green == out_item.blue))
  `HSLC_ASSERT_IMPL(a_black, out_valid && (out_lit_r == '0), (out_item.red == '0) && (out_item.green == '0) && (out_item.blue == '0))
  `HSLC_ASSERT_IMPL(a_white, out_valid && (out_lit_r == PCT_W'(PCT_MAX)), (out_item.red == 8'hFF) && (out_item.green == 8'hFF) && (out_item.blue == 8'hFF))

endmodule

`default_nettype wire
